// ===== hw/rtl/lsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants of the light sensor reader
// Holds the configuration and pipeline word types, the fixed-point constants
// of the lux conversion and the small helpers for decimal digits.
// ----------------------------------------------------------------------------
package lsr_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIndexW      = 8;
    localparam logic [CfgIndexW-1:0] CFG_SLAVE_ADDR = 8'd0;
    localparam logic [CfgIndexW-1:0] CFG_MODE_CMD   = 8'd1;
    localparam logic [CfgIndexW-1:0] CFG_WAIT_TICKS = 8'd2;
    localparam logic [CfgIndexW-1:0] CFG_GAP_TICKS  = 8'd3;
    localparam int unsigned CfgDataW       = 20;

    // Reset values of the registers
    localparam logic [7:0]  RST_SLAVE_ADDR = 8'h46;
    localparam logic [7:0]  RST_MODE_CMD   = 8'h10;
    localparam logic [19:0] RST_WAIT_TICKS = 20'd36000;
    localparam logic [19:0] RST_GAP_TICKS  = 20'd1000;

    localparam logic [7:0]  POWER_ON_CMD   = 8'h01;

    // lux = floor(raw * 5 / 6) = (raw * 5 * ceil(2^20 / 6)) >> 20, exact for 16-bit raw.
    localparam logic [19:0] LUX_MUL        = 20'd873815;
    // floor(x / 100) = (x * 83887) >> 23 for x below 2^16.
    localparam logic [16:0] DIV100_MUL     = 17'd83887;
    // floor(x / 100) = (x * 41) >> 12 for x below 1000.
    localparam logic [5:0]  DIV100_MUL_S   = 6'd41;
    // floor(x / 10) = (x * 205) >> 11 for x below 1024.
    localparam logic [7:0]  DIV10_MUL      = 8'd205;
    localparam logic [5:0]  ASCII_ZERO     = 6'd48;

    typedef struct packed {
        logic [7:0]  slave_write_address;
        logic [7:0]  mode_command;
        logic [19:0] conversion_wait_ticks;
        logic [19:0] cycle_gap_ticks;
    } t_cfg;

    // One bus tick as the sequencer leaves it.
    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sample_valid;
        logic [15:0] raw_level;
    } t_beat;

    // One finished result word; ascii[0] is the ten-thousands digit.
    typedef struct packed {
        logic            scl;
        logic            sda_out;
        logic            sample_valid;
        logic [15:0]     raw_level;
        logic [15:0]     lux;
        logic [4:0][5:0] ascii;
    } t_result;

    // Splits a value below 100 into its tens digit (upper nibble) and ones digit.
    function automatic logic [7:0] split_tens_ones(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'(DIV10_MUL);
        tens = prod[14:11];
        ones = 7'(v - 7'(7'(tens) * 7'd10));
        return {tens, ones[3:0]};
    endfunction

    function automatic logic [5:0] to_ascii(input logic [3:0] d);
        return ASCII_ZERO + 6'(d);
    endfunction

endpackage

// ===== hw/rtl/lsr_bus_seq.sv =====
// ----------------------------------------------------------------------------
// lsr_bus_seq: bus sequencer of the light sensor reader
// Steps one half-bit tick per accepted word: start, address and command bytes,
// two-byte read, stop and the idle phases, and latches the raw reading.
// ----------------------------------------------------------------------------
module lsr_bus_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_sda_in,
    input  lsr_pkg::t_cfg i_cfg,
    output lsr_pkg::t_beat o_beat
);

    typedef enum logic [2:0] {
        PH_START, PH_SEND, PH_SACK, PH_RECV, PH_MACK, PH_STOP, PH_WAIT, PH_GAP
    } t_phase;

    typedef enum logic [1:0] {
        TX_POWER, TX_MODE, TX_READ
    } t_txn;

    t_phase      r_phase, n_phase;
    t_txn        r_txn, n_txn;
    logic [19:0] r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic        r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_high, n_high;
    logic [15:0] r_raw, n_raw;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_sv, n_sv;

    always_comb begin
        n_phase = r_phase;
        n_txn   = r_txn;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_high  = r_high;
        n_raw   = r_raw;
        n_scl   = 1'b1;
        n_sda   = 1'b1;
        n_sv    = 1'b0;
        case (r_phase)
            PH_START: begin
                n_sda = (r_tick == 20'd0);
                if (r_tick == 20'd0) begin
                    n_tick = 20'd1;
                end else begin
                    n_phase = PH_SEND;
                    n_tick  = 20'd0;
                    n_bit   = 3'd0;
                    n_byte  = 1'b0;
                    n_shift = (r_txn == TX_READ) ? i_cfg.slave_write_address + 8'd1
                                                 : i_cfg.slave_write_address;
                end
            end
            PH_SEND: begin
                // Most significant bit goes out first.
                n_sda = r_shift[~r_bit];
                n_scl = r_tick[0];
                if (r_tick == 20'd0) begin
                    n_tick = 20'd1;
                end else begin
                    n_tick = 20'd0;
                    n_bit  = r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        n_phase = PH_SACK;
                    end
                end
            end
            PH_SACK: begin
                n_scl = r_tick[0];
                if (r_tick == 20'd0) begin
                    n_tick = 20'd1;
                end else begin
                    n_tick = 20'd0;
                    if (!r_byte && r_txn == TX_READ) begin
                        n_phase = PH_RECV;
                        n_shift = 8'd0;
                        n_bit   = 3'd0;
                    end else if (!r_byte) begin
                        n_byte  = 1'b1;
                        n_phase = PH_SEND;
                        n_bit   = 3'd0;
                        n_shift = (r_txn == TX_POWER) ? lsr_pkg::POWER_ON_CMD
                                                      : i_cfg.mode_command;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
            end
            PH_RECV: begin
                n_scl = r_tick[0];
                if (r_tick == 20'd0) begin
                    n_tick = 20'd1;
                end else begin
                    n_tick  = 20'd0;
                    n_shift = {r_shift[6:0], i_sda_in};
                    n_bit   = r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        n_phase = PH_MACK;
                        if (r_byte) begin
                            n_raw = {r_high, r_shift[6:0], i_sda_in};
                            n_sv  = 1'b1;
                        end
                    end
                end
            end
            PH_MACK: begin
                // Acknowledge the high byte, release the line after the low byte.
                n_sda = r_byte;
                n_scl = r_tick[0];
                if (r_tick == 20'd0) begin
                    n_tick = 20'd1;
                end else begin
                    n_tick = 20'd0;
                    if (!r_byte) begin
                        n_high  = r_shift;
                        n_byte  = 1'b1;
                        n_shift = 8'd0;
                        n_phase = PH_RECV;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                n_scl = (r_tick != 20'd0);
                n_sda = (r_tick == 20'd2);
                if (r_tick < 20'd2) begin
                    n_tick = r_tick + 20'd1;
                end else begin
                    n_tick = 20'd0;
                    case (r_txn)
                        TX_POWER: begin
                            n_txn   = TX_MODE;
                            n_phase = PH_START;
                        end
                        TX_MODE: begin
                            if (i_cfg.conversion_wait_ticks == 20'd0) begin
                                n_txn   = TX_READ;
                                n_phase = PH_START;
                            end else begin
                                n_phase = PH_WAIT;
                            end
                        end
                        default: begin
                            if (i_cfg.cycle_gap_ticks == 20'd0) begin
                                n_txn   = TX_POWER;
                                n_phase = PH_START;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end
                    endcase
                end
            end
            PH_WAIT: begin
                n_tick = r_tick + 20'd1;
                if (n_tick >= i_cfg.conversion_wait_ticks) begin
                    n_txn   = TX_READ;
                    n_phase = PH_START;
                    n_tick  = 20'd0;
                end
            end
            PH_GAP: begin
                n_tick = r_tick + 20'd1;
                if (n_tick >= i_cfg.cycle_gap_ticks) begin
                    n_txn   = TX_POWER;
                    n_phase = PH_START;
                    n_tick  = 20'd0;
                end
            end
            default: begin
                n_txn   = TX_POWER;
                n_phase = PH_START;
                n_tick  = 20'd0;
                n_bit   = 3'd0;
                n_byte  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_txn   <= TX_POWER;
            r_tick  <= 20'd0;
            r_bit   <= 3'd0;
            r_byte  <= 1'b0;
            r_shift <= 8'd0;
            r_high  <= 8'd0;
            r_raw   <= 16'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_sv    <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_txn   <= n_txn;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_high  <= n_high;
            r_raw   <= n_raw;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_sv    <= n_sv;
        end
    end

    assign o_beat = '{scl: r_scl, sda_out: r_sda, sample_valid: r_sv, raw_level: r_raw};

endmodule

// ===== hw/rtl/lsr_lux_pipe.sv =====
// ----------------------------------------------------------------------------
// lsr_lux_pipe: lux conversion and decimal digit pipeline
// Four register stages turn each tick's raw count into lux and five ASCII
// digits, using reciprocal multiplications instead of dividers.
// ----------------------------------------------------------------------------
module lsr_lux_pipe (
    input  logic             i_clk,
    input  logic             i_en,
    input  lsr_pkg::t_beat   i_beat,
    output lsr_pkg::t_result o_result
);

    lsr_pkg::t_beat  r_b1, r_b2, r_b3;
    logic [15:0]     r_lux1, r_lux2, r_lux3;
    logic [9:0]      r_q2, r_q3;
    logic [6:0]      r_rem3;
    logic [2:0]      r_top3;
    lsr_pkg::t_result r_res;

    logic [35:0] lux_prod;
    logic [32:0] q_prod;
    logic [15:0] q_scaled;
    logic [15:0] top_prod;
    logic [9:0]  top_scaled;
    logic [6:0]  mid;
    logic [7:0]  mid_digits, low_digits;

    assign lux_prod   = 36'(i_beat.raw_level) * 36'(lsr_pkg::LUX_MUL);
    assign q_prod     = 33'(r_lux1) * 33'(lsr_pkg::DIV100_MUL);
    assign q_scaled   = 16'(r_q2) * 16'd100;
    assign top_prod   = 16'(r_q2) * 16'(lsr_pkg::DIV100_MUL_S);
    // Thousands and hundreds come from the lux value divided by one hundred.
    assign top_scaled = 10'(r_top3) * 10'd100;
    assign mid        = 7'(r_q3 - top_scaled);
    assign mid_digits = lsr_pkg::split_tens_ones(mid);
    assign low_digits = lsr_pkg::split_tens_ones(r_rem3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1   <= i_beat;
            r_lux1 <= lux_prod[35:20];

            r_b2   <= r_b1;
            r_lux2 <= r_lux1;
            r_q2   <= q_prod[32:23];

            r_b3   <= r_b2;
            r_lux3 <= r_lux2;
            r_q3   <= r_q2;
            r_rem3 <= 7'(r_lux2 - q_scaled);
            r_top3 <= top_prod[14:12];

            r_res.scl          <= r_b3.scl;
            r_res.sda_out      <= r_b3.sda_out;
            r_res.sample_valid <= r_b3.sample_valid;
            r_res.raw_level    <= r_b3.raw_level;
            r_res.lux          <= r_lux3;
            r_res.ascii[0]     <= lsr_pkg::to_ascii(4'(r_top3));
            r_res.ascii[1]     <= lsr_pkg::to_ascii(mid_digits[7:4]);
            r_res.ascii[2]     <= lsr_pkg::to_ascii(mid_digits[3:0]);
            r_res.ascii[3]     <= lsr_pkg::to_ascii(low_digits[7:4]);
            r_res.ascii[4]     <= lsr_pkg::to_ascii(low_digits[3:0]);
        end
    end

    assign o_result = r_res;

endmodule

// ===== hw/rtl/i2c_light_sensor_reader_top.sv =====
// ----------------------------------------------------------------------------
// i2c_light_sensor_reader_top: bit-level bus master for a light sensor
// Throughput: one tick word per clock while no result word is held at the output.
// A result word is valid once its tick word has passed the sequencer register and then
// the four conversion stages; a held result word stalls both sides.
// Reset: synchronous, active low; bus at the start of the power-on write,
// registers at their defaults, pipeline emptied, no word taken while reset is held.
// ----------------------------------------------------------------------------
module i2c_light_sensor_reader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] sda_in, rest zero
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // scl, sda_out, raw_level, lux, ascii ten
                                          // thousands, thousands, hundreds, tens, ones
    output logic        o_m_axis_tuser,   // sample_valid
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lsr_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [lsr_pkg::CfgDataW-1:0]  i_cfg_data
);

    lsr_pkg::t_cfg    r_cfg;
    lsr_pkg::t_beat   beat;
    lsr_pkg::t_result result;
    logic [4:0]       r_vld;
    logic             en;
    logic             s_acc;

    // The whole pipeline moves unless a finished word is held at the output.
    assign en              = !r_vld[4] || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_write_address   <= lsr_pkg::RST_SLAVE_ADDR;
            r_cfg.mode_command          <= lsr_pkg::RST_MODE_CMD;
            r_cfg.conversion_wait_ticks <= lsr_pkg::RST_WAIT_TICKS;
            r_cfg.cycle_gap_ticks       <= lsr_pkg::RST_GAP_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lsr_pkg::CFG_SLAVE_ADDR: r_cfg.slave_write_address   <= i_cfg_data[7:0];
                lsr_pkg::CFG_MODE_CMD:   r_cfg.mode_command          <= i_cfg_data[7:0];
                lsr_pkg::CFG_WAIT_TICKS: r_cfg.conversion_wait_ticks <= i_cfg_data;
                lsr_pkg::CFG_GAP_TICKS:  r_cfg.cycle_gap_ticks       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_s_axis_tvalid};
        end
    end

    lsr_bus_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_acc),
        .i_sda_in (i_s_axis_tdata[0]),
        .i_cfg    (r_cfg),
        .o_beat   (beat)
    );

    lsr_lux_pipe u_pipe (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_beat   (beat),
        .o_result (result)
    );

    assign o_m_axis_tvalid = r_vld[4];
    assign o_m_axis_tuser  = result.sample_valid;
    assign o_m_axis_tdata  = {result.ascii[4], result.ascii[3], result.ascii[2],
                              result.ascii[1], result.ascii[0], result.lux,
                              result.raw_level, result.sda_out, result.scl};

    a_acc_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_vld[0])
        else $error("accepted tick word did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while the output was stalled");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> (r_vld[4:1] == $past(r_vld[3:0])))
        else $error("pipeline valid bits did not advance together");

    a_latch_on_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && beat.sample_valid) |-> beat.scl)
        else $error("reading latched on a low clock tick");

endmodule
